/* hw/rtl/jeoi_pkg.sv */
// Shared types, constants and codes for the JPEG end-of-image and trailer finder.
package jeoi_pkg;

  localparam int POS_BITS_DEF = 32;
  // Room for a 15-digit decimal value.
  localparam int VAL_BITS     = 50;
  localparam int WIN_LEN      = 20;
  localparam int TAG_LEN      = 5;
  localparam int DIGIT_COUNT  = 15;
  localparam int TRAILER_SIZE = 60;
  localparam int MIN_VIDEO    = 20;
  localparam int MIN_FILE     = 4;
  localparam int DCNT_BITS    = $clog2(DIGIT_COUNT);

  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_00   = 8'h00;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_RST0   = 8'hD0;
  localparam logic [7:0] MK_RST7   = 8'hD7;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [7:0] LIVE_TAG [TAG_LEN] = '{8'h4C, 8'h49, 8'h56, 8'h45, 8'h5F};

  typedef enum logic [3:0] {
    PH_START0,
    PH_START1,
    PH_EXPECT_FF,
    PH_FILL,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_SOS_LEN_HI,
    PH_SOS_LEN_LO,
    PH_SOS_SKIP,
    PH_ENTROPY,
    PH_DONE,
    PH_BAD_START
  } phase_t;

  typedef enum logic [3:0] {
    J_IDLE,
    J_CHECK,
    J_EOI,
    J_DIGIT,
    J_VMIN,
    J_VMAX,
    J_START,
    J_VOFF,
    J_OVL,
    J_OUT
  } jstate_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_NO_TRAILER = 3'd2,
    ST_BAD_LEN    = 3'd3,
    ST_BEFORE     = 3'd4,
    ST_OVERLAP    = 3'd5
  } status_t;

  typedef enum logic {
    ALU_SUB,
    ALU_MAC
  } alu_op_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] eoi_offset;
    logic [31:0] clip_offset;
    logic [31:0] clip_length;
    logic [31:0] file_length;
  } out_item_t;

  function automatic logic is_rst(input logic [7:0] b);
    return (b >= MK_RST0) && (b <= MK_RST7);
  endfunction

endpackage

/* hw/rtl/jpeg_eoi_and_tail_trailer_finder.sv */
// Ordinary bytes are taken one per cycle while in_stall is low and give no result.
// The end-of-file byte starts the trailer check: out_valid rises once the check sequencer is done,
// which runs 15 digit steps plus up to 7 compare steps on one shared unit.
// Input is stalled from that byte until the result is taken; then the next file may start.
// Reset (rst_n low, synchronous) clears the walker and sequencer; the tail window is not reset.
module jpeg_eoi_and_tail_trailer_finder import jeoi_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic                accept;
  logic                busy;
  logic                done;
  logic [POS_BITS-1:0] byte_count;
  logic [POS_BITS-1:0] eoi_pos;
  logic                start_bad;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  jeoi_walker #(
    .POS_BITS (POS_BITS)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data.data_byte),
    .clear      (done),
    .byte_count (byte_count),
    .eoi_pos    (eoi_pos),
    .start_bad  (start_bad)
  );

  jeoi_judge #(
    .POS_BITS (POS_BITS)
  ) u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data.data_byte),
    .end_of_file (in_data.end_of_file),
    .byte_count  (byte_count),
    .eoi_pos     (eoi_pos),
    .start_bad   (start_bad),
    .out_stall   (out_stall),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_item    (out_data),
    .done        (done)
  );

endmodule

/* hw/rtl/jeoi_walker.sv */
// Byte-stream marker segment walker: byte count, scan phase and end-of-image position.
module jeoi_walker import jeoi_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                clear,
  output logic [POS_BITS-1:0] byte_count,
  output logic [POS_BITS-1:0] eoi_pos,
  output logic                start_bad
);

  phase_t              phase_r, phase_nxt;
  logic [POS_BITS-1:0] count_r, count_nxt;
  logic [POS_BITS-1:0] eoi_r, eoi_nxt;
  logic [15:0]         rem_r, rem_nxt;
  logic [7:0]          len_hi_r, len_hi_nxt;
  logic                saw_ff_r, saw_ff_nxt;
  logic [POS_BITS-1:0] count_inc;
  logic [15:0]         seg_len;
  logic [15:0]         rem_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START0;
      count_r  <= '0;
      eoi_r    <= '0;
      rem_r    <= '0;
      len_hi_r <= '0;
      saw_ff_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      eoi_r    <= eoi_nxt;
      rem_r    <= rem_nxt;
      len_hi_r <= len_hi_nxt;
      saw_ff_r <= saw_ff_nxt;
    end
  end

  always_comb begin
    // saturate at all ones
    count_inc  = (count_r == '1) ? count_r : count_r + 1'b1;
    seg_len    = {len_hi_r, data_byte};
    rem_dec    = (rem_r != '0) ? rem_r - 16'd1 : rem_r;
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    eoi_nxt    = eoi_r;
    rem_nxt    = rem_r;
    len_hi_nxt = len_hi_r;
    saw_ff_nxt = saw_ff_r;
    if (clear) begin
      phase_nxt  = PH_START0;
      count_nxt  = '0;
      eoi_nxt    = '0;
      rem_nxt    = '0;
      len_hi_nxt = '0;
      saw_ff_nxt = 1'b0;
    end else if (accept) begin
      count_nxt = count_inc;
      case (phase_r)
        PH_START0: begin
          phase_nxt = (data_byte == BYTE_FF) ? PH_START1 : PH_BAD_START;
        end
        PH_START1: begin
          phase_nxt = (data_byte == MK_SOI) ? PH_EXPECT_FF : PH_BAD_START;
        end
        PH_EXPECT_FF: begin
          phase_nxt = (data_byte == BYTE_FF) ? PH_FILL : PH_DONE;
        end
        PH_FILL: begin
          if (data_byte == BYTE_FF) begin
            phase_nxt = PH_FILL;
          end else if (data_byte == BYTE_00 || is_rst(data_byte)) begin
            phase_nxt = PH_DONE;
          end else if (data_byte == MK_EOI) begin
            eoi_nxt   = count_inc;
            phase_nxt = PH_DONE;
          end else if (data_byte == MK_SOS) begin
            phase_nxt = PH_SOS_LEN_HI;
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_hi_nxt = data_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_SOS_LEN_HI: begin
          len_hi_nxt = data_byte;
          phase_nxt  = PH_SOS_LEN_LO;
        end
        PH_LEN_LO: begin
          if (seg_len < 16'd2) begin
            phase_nxt = PH_DONE;
          end else begin
            rem_nxt   = seg_len - 16'd2;
            phase_nxt = (seg_len == 16'd2) ? PH_EXPECT_FF : PH_SKIP;
          end
        end
        PH_SOS_LEN_LO: begin
          if (seg_len < 16'd2) begin
            phase_nxt = PH_DONE;
          end else begin
            rem_nxt   = seg_len - 16'd2;
            phase_nxt = (seg_len == 16'd2) ? PH_ENTROPY : PH_SOS_SKIP;
          end
        end
        PH_SKIP: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) phase_nxt = PH_EXPECT_FF;
        end
        PH_SOS_SKIP: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) phase_nxt = PH_ENTROPY;
        end
        PH_ENTROPY: begin
          if (saw_ff_r && data_byte == MK_EOI) begin
            eoi_nxt    = count_inc;
            phase_nxt  = PH_DONE;
            saw_ff_nxt = 1'b0;
          end else if (saw_ff_r && (data_byte == BYTE_00 || is_rst(data_byte))) begin
            // stuffed byte or restart marker: keep scanning
            saw_ff_nxt = 1'b0;
          end else begin
            saw_ff_nxt = (data_byte == BYTE_FF);
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  assign byte_count = count_r;
  assign eoi_pos    = eoi_r;
  assign start_bad  = (phase_r == PH_START0) || (phase_r == PH_START1) ||
                      (phase_r == PH_BAD_START);

endmodule

/* hw/rtl/jeoi_alu.sv */
// Shared arithmetic unit: subtract with borrow, or decimal multiply-accumulate.
module jeoi_alu import jeoi_pkg::*; (
  input  alu_op_t             op,
  input  logic [VAL_BITS-1:0] a,
  input  logic [VAL_BITS-1:0] b,
  input  logic [3:0]          digit,
  output logic [VAL_BITS-1:0] res,
  output logic                borrow
);

  logic [VAL_BITS:0] diff;

  always_comb begin
    diff   = {1'b0, a} - {1'b0, b};
    res    = diff[VAL_BITS-1:0];
    borrow = diff[VAL_BITS];
    case (op)
      ALU_MAC: begin
        // a * 10 + digit
        res    = (a << 3) + (a << 1) + VAL_BITS'(digit);
        borrow = 1'b0;
      end
      ALU_SUB: begin
        res    = diff[VAL_BITS-1:0];
        borrow = diff[VAL_BITS];
      end
      default: begin
        res    = diff[VAL_BITS-1:0];
        borrow = diff[VAL_BITS];
      end
    endcase
  end

endmodule

/* hw/rtl/jeoi_judge.sv */
// Tail window and trailer check sequencer driving the shared arithmetic unit.
module jeoi_judge import jeoi_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                end_of_file,
  input  logic [POS_BITS-1:0] byte_count,
  input  logic [POS_BITS-1:0] eoi_pos,
  input  logic                start_bad,
  input  logic                out_stall,
  output logic                busy,
  output logic                out_valid,
  output out_item_t           out_item,
  output logic                done
);

  localparam int EXT_BITS = (POS_BITS >= 32) ? POS_BITS : 32;

  jstate_t              state_r, state_nxt;
  logic [7:0]           win_r [WIN_LEN];
  logic [DCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [VAL_BITS-1:0]  val_r, val_nxt;
  logic [VAL_BITS-1:0]  vl_r, vl_nxt;
  logic [VAL_BITS-1:0]  start_r, start_nxt;
  logic [VAL_BITS-1:0]  off_r, off_nxt;
  logic                 in_dig_r, in_dig_nxt;
  logic                 any_dig_r, any_dig_nxt;
  logic                 pad_bad_r, pad_bad_nxt;
  status_t              status_r, status_nxt;

  alu_op_t              alu_op;
  logic [VAL_BITS-1:0]  alu_a, alu_b, alu_res;
  logic [3:0]           alu_digit;
  logic                 alu_borrow;

  logic [VAL_BITS-1:0]  len_ext, eoi_ext;
  logic [EXT_BITS-1:0]  len_w, eoi_w;
  logic [7:0]           cur_ch;
  logic                 cur_is_digit;
  logic                 tag_ok;
  logic                 shift_win;

  jeoi_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .digit  (alu_digit),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  assign len_ext      = VAL_BITS'(byte_count);
  assign eoi_ext      = VAL_BITS'(eoi_pos);
  assign len_w        = EXT_BITS'(byte_count);
  assign eoi_w        = EXT_BITS'(eoi_pos);
  assign cur_ch       = win_r[TAG_LEN];
  assign cur_is_digit = (cur_ch >= CH_ZERO) && (cur_ch <= CH_NINE);
  assign shift_win    = (state_r == J_DIGIT);

  always_comb begin
    tag_ok = 1'b1;
    for (int i = 0; i < TAG_LEN; i++) begin
      if (win_r[i] != LIVE_TAG[i]) tag_ok = 1'b0;
    end
  end

  // Stream bytes enter at the top; during the digit pass the window advances toward index 0.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WIN_LEN - 1; i++) win_r[i] <= win_r[i+1];
      win_r[WIN_LEN-1] <= data_byte;
    end else if (shift_win) begin
      for (int i = 0; i < WIN_LEN - 1; i++) win_r[i] <= win_r[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= J_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    val_r     <= val_nxt;
    vl_r      <= vl_nxt;
    start_r   <= start_nxt;
    off_r     <= off_nxt;
    in_dig_r  <= in_dig_nxt;
    any_dig_r <= any_dig_nxt;
    pad_bad_r <= pad_bad_nxt;
    status_r  <= status_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    val_nxt     = val_r;
    vl_nxt      = vl_r;
    start_nxt   = start_r;
    off_nxt     = off_r;
    in_dig_nxt  = in_dig_r;
    any_dig_nxt = any_dig_r;
    pad_bad_nxt = pad_bad_r;
    status_nxt  = status_r;
    alu_op      = ALU_SUB;
    alu_a       = val_r;
    alu_b       = '0;
    alu_digit   = cur_ch[3:0];
    done        = 1'b0;
    case (state_r)
      J_IDLE: begin
        if (accept && end_of_file) state_nxt = J_CHECK;
      end
      J_CHECK: begin
        cnt_nxt     = '0;
        val_nxt     = '0;
        in_dig_nxt  = 1'b1;
        any_dig_nxt = 1'b0;
        pad_bad_nxt = 1'b0;
        if (start_bad || byte_count < POS_BITS'(MIN_FILE)) begin
          status_nxt = ST_BAD_START;
          state_nxt  = J_OUT;
        end else if (eoi_pos == '0 || byte_count < POS_BITS'(TRAILER_SIZE) || !tag_ok) begin
          status_nxt = ST_NO_TRAILER;
          state_nxt  = J_OUT;
        end else begin
          state_nxt = J_EOI;
        end
      end
      J_EOI: begin
        // marker must not sit on the last byte
        alu_a = eoi_ext;
        alu_b = len_ext;
        if (!alu_borrow) begin
          status_nxt = ST_NO_TRAILER;
          state_nxt  = J_OUT;
        end else begin
          state_nxt = J_DIGIT;
        end
      end
      J_DIGIT: begin
        alu_op = ALU_MAC;
        alu_a  = val_r;
        if (in_dig_r && cur_is_digit) begin
          val_nxt     = alu_res;
          any_dig_nxt = 1'b1;
        end else begin
          in_dig_nxt = 1'b0;
          if (cur_ch != CH_SPACE && cur_ch != BYTE_00) pad_bad_nxt = 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DCNT_BITS'(DIGIT_COUNT - 1)) state_nxt = J_VMIN;
      end
      J_VMIN: begin
        alu_a = val_r;
        alu_b = VAL_BITS'(MIN_VIDEO);
        vl_nxt = alu_res;
        if (!any_dig_r || pad_bad_r || alu_borrow || alu_res == '0) begin
          status_nxt = ST_BAD_LEN;
          state_nxt  = J_OUT;
        end else begin
          state_nxt = J_VMAX;
        end
      end
      J_VMAX: begin
        alu_a = len_ext;
        alu_b = val_r;
        if (alu_borrow) begin
          status_nxt = ST_BAD_LEN;
          state_nxt  = J_OUT;
        end else begin
          state_nxt = J_START;
        end
      end
      J_START: begin
        alu_a     = len_ext;
        alu_b     = VAL_BITS'(TRAILER_SIZE);
        start_nxt = alu_res;
        state_nxt = J_VOFF;
      end
      J_VOFF: begin
        alu_a   = start_r;
        alu_b   = vl_r;
        off_nxt = alu_res;
        if (alu_borrow) begin
          status_nxt = ST_BEFORE;
          state_nxt  = J_OUT;
        end else begin
          state_nxt = J_OVL;
        end
      end
      J_OVL: begin
        alu_a      = off_r;
        alu_b      = eoi_ext;
        status_nxt = alu_borrow ? ST_OVERLAP : ST_OK;
        state_nxt  = J_OUT;
      end
      J_OUT: begin
        if (!out_stall) begin
          done      = 1'b1;
          state_nxt = J_IDLE;
        end
      end
      default: begin
        state_nxt = J_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != J_IDLE);
  assign out_valid = (state_r == J_OUT);

  always_comb begin
    out_item.status      = status_r;
    out_item.eoi_offset  = (status_r == ST_BAD_START) ? 32'd0 : eoi_w[31:0];
    out_item.clip_offset = (status_r == ST_OK) ? off_r[31:0] : 32'd0;
    out_item.clip_length = (status_r == ST_OK) ? vl_r[31:0] : 32'd0;
    out_item.file_length = len_w[31:0];
  end

endmodule
